/* rtl/core/mic_pkg.sv */
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants for the magnetometer iron calibration core.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int AXES   = 3;
  localparam int AXIS_W = 2;
  localparam int CFG_W  = 16;
  localparam int SEEN_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 16'd256;

  typedef logic [AXIS_W-1:0] mic_axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_NUM,
    ST_SUB,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } mic_state_t;

  typedef struct packed {
    logic      accept;
    logic      coef_load;
    logic      num_load;
    logic      sub_load;
    logic      mul_load;
    logic      div_start;
    logic      res_load;
    logic      res_zero;
    logic      out_load;
    mic_axis_t axis;
  } mic_cmd_t;

  typedef struct packed {
    logic cal_eff;
    logic cal_end;
    logic div_done;
    logic dvs_zero;
    logic out_free;
  } mic_sts_t;

endpackage

/* rtl/core/mic_in_if.sv */
// ----------------------------------------------------------------------------
// mic_in_if
// Raw sample channel: three axis samples and a restart flag.
// ----------------------------------------------------------------------------
interface mic_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic signed [SAMPLE_BITS-1:0] raw_y;
  logic signed [SAMPLE_BITS-1:0] raw_z;
  logic                          restart;

  modport source (output valid, raw_x, raw_y, raw_z, restart, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, restart, output ready);
endinterface

/* rtl/core/mic_out_if.sv */
// ----------------------------------------------------------------------------
// mic_out_if
// Corrected sample channel: three corrected axes and a per-axis fault mask.
// ----------------------------------------------------------------------------
interface mic_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] corr_x;
  logic signed [SAMPLE_BITS-1:0] corr_y;
  logic signed [SAMPLE_BITS-1:0] corr_z;
  logic [2:0]                    fault_mask;

  modport source (output valid, corr_x, corr_y, corr_z, fault_mask, input ready);
  modport sink   (input valid, corr_x, corr_y, corr_z, fault_mask, output ready);
endinterface

/* rtl/core/mic_div.sv */
// ----------------------------------------------------------------------------
// mic_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mic_div #(
  parameter int DW = 30,
  parameter int VW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW:0]   rem_r;
  logic [VW-1:0] dvs_r;

  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW:0]   rem_nxt;
  logic [DW-1:0] quo_nxt;

  assign rem_sh  = {rem_r[VW-1:0], quo_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  assign quo_nxt = {quo_r[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < {1'b0, dvs_r}))
    else $error("divider remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $fell(busy_r))
    else $error("divider done without finishing");

endmodule

/* rtl/core/mic_ctrl.sv */
// ----------------------------------------------------------------------------
// mic_ctrl
// Sequencer: calibration bookkeeping, coefficient computation and the
// per-axis subtract, multiply, divide sequence.
// ----------------------------------------------------------------------------
module mic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mic_pkg::mic_sts_t sts,
  output mic_pkg::mic_cmd_t cmd
);
  import mic_pkg::*;

  mic_state_t state_r, state_nxt;
  mic_axis_t  axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        axis_nxt = '0;
        if (in_valid) begin
          if (sts.cal_eff) begin
            state_nxt = ST_SUB;
          end else if (sts.cal_end) begin
            state_nxt = ST_COEF;
          end
        end
      end
      ST_COEF:      state_nxt = ST_NUM;
      ST_NUM:       state_nxt = ST_IDLE;
      ST_SUB:       state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: begin
        if (sts.dvs_zero) begin
          axis_nxt  = (axis_r == AXIS_W'(AXES - 1)) ? '0 : axis_r + AXIS_W'(1);
          state_nxt = (axis_r == AXIS_W'(AXES - 1)) ? ST_OUT : ST_SUB;
        end else begin
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          axis_nxt  = (axis_r == AXIS_W'(AXES - 1)) ? '0 : axis_r + AXIS_W'(1);
          state_nxt = (axis_r == AXIS_W'(AXES - 1)) ? ST_OUT : ST_SUB;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_COEF:      cmd.coef_load = 1'b1;
      ST_NUM:       cmd.num_load  = 1'b1;
      ST_SUB:       cmd.sub_load  = 1'b1;
      ST_MUL:       cmd.mul_load  = 1'b1;
      ST_DIV_START: begin
        cmd.res_zero  = sts.dvs_zero;
        cmd.div_start = !sts.dvs_zero;
      end
      ST_DIV_WAIT:  cmd.res_load = sts.div_done;
      ST_OUT:       cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r <= AXIS_W'(AXES - 1))
    else $error("axis index out of range");

  a_axis_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_WAIT && !sts.div_done) |=> $stable(axis_r))
    else $error("axis changed during division");

endmodule

/* rtl/core/mic_dp.sv */
// ----------------------------------------------------------------------------
// mic_dp
// Datapath: min/max tracking, coefficients, shared multiplier, divider
// operands and the output register.
// ----------------------------------------------------------------------------
module mic_dp #(
  parameter int SB = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mic_pkg::mic_cmd_t            cmd,
  output mic_pkg::mic_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [mic_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic signed [SB-1:0]         raw_x,
  input  logic signed [SB-1:0]         raw_y,
  input  logic signed [SB-1:0]         raw_z,
  input  logic                         restart,
  output logic                         div_start,
  output logic [2*SB-3:0]              div_dividend,
  output logic [SB-2:0]                div_divisor,
  input  logic                         div_done,
  input  logic [2*SB-3:0]              div_quotient,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [SB-1:0]         corr_x,
  output logic signed [SB-1:0]         corr_y,
  output logic signed [SB-1:0]         corr_z,
  output logic [2:0]                   fault_mask
);
  import mic_pkg::*;

  localparam int PW  = 2 * SB;
  localparam int MW  = 2 * SB - 2;
  localparam int DVW = SB - 1;
  localparam int NK  = SB + 2;
  localparam int NPW = 2 * SB + 2;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  // ceil(2^NK / 3): exact floor division by 3 for sums below 2^(SB+1)
  localparam logic [SB:0] NUM_RECIP = (SB+1)'(((64'd1 << NK) + 64'd2) / 64'd3);

  logic [CFG_W-1:0]     cfg_r;
  logic [SEEN_W-1:0]    seen_r;
  logic                 cal_r;
  logic signed [SB-1:0] max_r [AXES];
  logic signed [SB-1:0] min_r [AXES];
  logic signed [SB-1:0] smp_r [AXES];
  logic signed [SB-1:0] off_r [AXES];
  logic [DVW-1:0]       dvs_r [AXES];
  logic [DVW-1:0]       num_r;
  logic signed [SB-1:0] t_r;
  logic signed [PW-1:0] prod_r;
  logic                 neg_r;
  logic signed [SB-1:0] res_r [AXES];
  logic [AXES-1:0]      flt_r;
  logic                 out_valid_r;

  logic signed [SB-1:0] raw [AXES];
  logic signed [SB-1:0] max_nxt [AXES];
  logic signed [SB-1:0] min_nxt [AXES];
  logic signed [SB:0]   mm_sum [AXES];
  logic signed [SB:0]   mm_dif [AXES];
  logic [SEEN_W-1:0]    seen_nxt;
  logic [SB:0]          dvs_sum;
  logic [NPW-1:0]       num_prod;
  logic signed [PW-1:0] t_ext;
  logic signed [PW-1:0] n_ext;
  logic [PW-1:0]        prod_mag;
  logic [MW-1:0]        quo_sgn;

  assign raw[0] = raw_x;
  assign raw[1] = raw_y;
  assign raw[2] = raw_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      logic signed [SB-1:0] mx;
      logic signed [SB-1:0] mn;
      mx         = restart ? S_MIN : max_r[a];
      mn         = restart ? S_MAX : min_r[a];
      max_nxt[a] = (raw[a] > mx) ? raw[a] : mx;
      min_nxt[a] = (raw[a] < mn) ? raw[a] : mn;
      mm_sum[a]  = {max_r[a][SB-1], max_r[a]} + {min_r[a][SB-1], min_r[a]};
      mm_dif[a]  = {max_r[a][SB-1], max_r[a]} - {min_r[a][SB-1], min_r[a]};
    end
  end

  assign seen_nxt = (restart ? '0 : seen_r) + SEEN_W'(1);
  assign dvs_sum  = (SB+1)'(dvs_r[0]) + (SB+1)'(dvs_r[1]) + (SB+1)'(dvs_r[2]);
  assign num_prod = NPW'(dvs_sum) * NPW'(NUM_RECIP);
  assign t_ext    = PW'(t_r);
  assign n_ext    = $signed({{(PW-DVW){1'b0}}, num_r});
  assign prod_mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  assign quo_sgn  = neg_r ? (~div_quotient + MW'(1)) : div_quotient;

  assign sts.cal_eff  = cal_r && !restart;
  assign sts.cal_end  = (seen_nxt >= cfg_r) || (seen_nxt == '0);
  assign sts.div_done = div_done;
  assign sts.dvs_zero = (dvs_r[cmd.axis] == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign div_start    = cmd.div_start;
  assign div_dividend = prod_mag[MW-1:0];
  assign div_divisor  = dvs_r[cmd.axis];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      seen_r      <= '0;
      cal_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        max_r[a] <= S_MIN;
        min_r[a] <= S_MAX;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.accept && !sts.cal_eff) begin
        seen_r <= seen_nxt;
        cal_r  <= 1'b0;
        for (int a = 0; a < AXES; a++) begin
          max_r[a] <= max_nxt[a];
          min_r[a] <= min_nxt[a];
        end
      end
      if (cmd.num_load) begin
        cal_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int a = 0; a < AXES; a++) begin
        smp_r[a] <= raw[a];
      end
    end
    if (cmd.coef_load) begin
      for (int a = 0; a < AXES; a++) begin
        off_r[a] <= mm_sum[a][SB:1];
        dvs_r[a] <= mm_dif[a][SB-1:1];
      end
    end
    if (cmd.num_load) begin
      num_r <= num_prod[NK +: DVW];
    end
    if (cmd.sub_load) begin
      t_r <= smp_r[cmd.axis] - off_r[cmd.axis];
    end
    if (cmd.mul_load) begin
      prod_r <= t_ext * n_ext;
    end
    if (cmd.div_start) begin
      neg_r <= prod_r[PW-1];
    end
    if (cmd.res_load) begin
      res_r[cmd.axis] <= quo_sgn[SB-1:0];
      flt_r[cmd.axis] <= 1'b0;
    end
    if (cmd.res_zero) begin
      res_r[cmd.axis] <= '0;
      flt_r[cmd.axis] <= 1'b1;
    end
    if (cmd.out_load) begin
      corr_x     <= res_r[0];
      corr_y     <= res_r[1];
      corr_z     <= res_r[2];
      fault_mask <= flt_r;
    end
  end

  assign out_valid = out_valid_r;

  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r != '0) |-> (max_r[0] >= min_r[0] && max_r[1] >= min_r[1] &&
                        max_r[2] >= min_r[2]))
    else $error("axis min above max after calibration sample");

  a_cal_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cal_r) |-> $past(cmd.num_load))
    else $error("calibrated set without coefficient load");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(corr_x) && $stable(fault_mask))
    else $error("pending result overwritten");

endmodule

/* rtl/core/magnetometer_iron_calibration_core.sv */
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_core
// Hard/soft iron calibration of three-axis magnetometer samples by min/max.
// ----------------------------------------------------------------------------
// The first cfg_wdata-programmed number of samples (default 256), or the
// samples from a restart onward, only update the per-axis min/max and give
// no transaction on the output channel. A calibration sample is accepted in
// the idle state; after the last one the offsets and divisors, and then the
// shared numerator, are formed. Every later sample gives one output
// transaction and waits on the bit-serial divider that the three axes share,
// one quotient bit per cycle; an axis with a zero divisor skips its division,
// outputs 0 and sets its fault bit. A result waiting on the output does not
// block the next sample until that sample needs the output register.
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mic_in_if.sink                    in_chan,
  mic_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [mic_pkg::CFG_W-1:0] cfg_wdata
);
  import mic_pkg::*;

  localparam int MW  = 2 * SAMPLE_BITS - 2;
  localparam int DVW = SAMPLE_BITS - 1;

  mic_cmd_t       cmd;
  mic_sts_t       sts;
  logic           div_start;
  logic [MW-1:0]  div_dividend;
  logic [DVW-1:0] div_divisor;
  logic           div_done;
  logic [MW-1:0]  div_quotient;

  mic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mic_div #(
    .DW (MW),
    .VW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  mic_dp #(
    .SB (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .raw_x        (in_chan.raw_x),
    .raw_y        (in_chan.raw_y),
    .raw_z        (in_chan.raw_z),
    .restart      (in_chan.restart),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .corr_x       (out_chan.corr_x),
    .corr_y       (out_chan.corr_y),
    .corr_z       (out_chan.corr_z),
    .fault_mask   (out_chan.fault_mask)
  );

endmodule
